/* rtl/tdfs_pkg.sv */
// Package for the table-driven state machine: sizes, register indexes, the
// table row layout and the structs passed between the scan engine and the top level.
// No dependencies.
`default_nettype none

package tdfs_pkg;

    localparam int ROWS        = 16;
    localparam int DATA_WIDTH  = 16;
    localparam int STATE_WIDTH = 8;

    localparam int ROW_AW    = $clog2(ROWS);
    localparam int CNT_W     = $clog2(ROWS + 1);
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_BITS = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_CLOCK = 1'b1;

    typedef struct packed {
        logic [STATE_WIDTH-1:0] state;
        logic [DATA_WIDTH-1:0]  pattern;
        logic [DATA_WIDTH-1:0]  mask;
        logic [STATE_WIDTH-1:0] next;
        logic [DATA_WIDTH-1:0]  outval;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_SCAN_T = 4'b0010,
        PH_SCAN_O = 4'b0100,
        PH_FINISH = 4'b1000
    } t_phase;

    // Request for one clock item, already masked to the configured widths.
    typedef struct packed {
        logic                  start;
        logic                  unknown;
        logic [DATA_WIDTH-1:0] x;
        logic [DATA_WIDTH-1:0] omask;
        logic [CNT_W-1:0]      count;
    } t_scan_req;

    typedef struct packed {
        logic                   done;
        logic [DATA_WIDTH-1:0]  value;
        logic                   unknown;
        logic                   changed;
        logic [STATE_WIDTH-1:0] state;
    } t_scan_res;

    typedef struct packed {
        logic                   idle;
        logic [STATE_WIDTH-1:0] state;
        logic [DATA_WIDTH-1:0]  last_out;
        logic                   last_unk;
    } t_status;

    // Low w bits set; a width above DATA_WIDTH saturates, zero gives no bits.
    function automatic logic [DATA_WIDTH-1:0] width_mask(input logic [CFG_W-1:0] w);
        logic [DATA_WIDTH-1:0] m;
        for (int b = 0; b < DATA_WIDTH; b++) begin
            m[b] = (b < int'(w));
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* rtl/tdfs_if.sv */
// Valid/ready channel interfaces for input items and result items of the
// table-driven state machine. No dependencies.
`default_nettype none

interface tdfs_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] in_value;
    logic        in_unknown;
    logic [3:0]  row_index;
    logic [7:0]  row_state;
    logic [15:0] row_pattern;
    logic [15:0] row_mask;
    logic [7:0]  row_next;
    logic [15:0] row_output;

    modport source (output valid, operation, in_value, in_unknown, row_index, row_state,
                    row_pattern, row_mask, row_next, row_output, input ready);
    modport sink (input valid, operation, in_value, in_unknown, row_index, row_state,
                  row_pattern, row_mask, row_next, row_output, output ready);
endinterface

interface tdfs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_value;
    logic        out_unknown;
    logic        out_changed;
    logic [7:0]  present_state;

    modport source (output valid, out_value, out_unknown, out_changed, present_state,
                    input ready);
    modport sink (input valid, out_value, out_unknown, out_changed, present_state,
                  output ready);
endinterface

`default_nettype wire

/* rtl/table_driven_fsm_step.sv */
// Top level of the table-driven state machine: configuration registers,
// input decode, row table RAM, scan engine and the result register.
// Depends on tdfs_pkg, tdfs_if, tdfs_ram and tdfs_engine.
`default_nettype none

// A load item writes one row of the 16-entry table RAM and yields its result in
// the cycle after it is accepted. A clock item is matched against the table by a
// scan that reads one row per cycle through the RAM's single read port: a pass
// over the rows for the transition, then a pass for the output of the new state,
// each ending at the first hit. An unknown input skips both passes. A result held
// back by the output port holds the engine in its finish phase, and no new item
// is taken until the scan's result has left the engine. The table needs no
// clearing after reset, but every row within the row count must be loaded before
// it is scanned.
module table_driven_fsm_step (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    tdfs_in_if.sink                               i_in,
    tdfs_out_if.source                            o_out,
    input  wire logic                             i_cfg_we,
    input  wire logic [tdfs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [tdfs_pkg::CFG_W-1:0]       i_cfg_data
);
    import tdfs_pkg::*;

    logic [CFG_W-1:0] r_row_count, r_input_bits, r_output_bits;

    logic                   r_out_valid, n_out_valid;
    logic [15:0]            r_out_value, n_out_value;
    logic                   r_out_unknown, n_out_unknown;
    logic                   r_out_changed, n_out_changed;
    logic [7:0]             r_out_state, n_out_state;

    t_scan_req   req;
    t_scan_res   res;
    t_status     status;
    t_row        wr_row, rd_row;
    logic        slot_free, accept, load, ram_we, rd_en;
    logic [ROW_AW-1:0] rd_addr;

    assign slot_free  = !r_out_valid || o_out.ready;
    assign i_in.ready = status.idle && slot_free;
    assign accept     = i_in.valid && i_in.ready;
    assign load       = accept && (i_in.operation == OP_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count   <= '0;
            r_input_bits  <= CFG_W'(16);
            r_output_bits <= CFG_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROW_COUNT:   r_row_count   <= i_cfg_data;
                CFG_INPUT_BITS:  r_input_bits  <= i_cfg_data;
                CFG_OUTPUT_BITS: r_output_bits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign wr_row.state   = STATE_WIDTH'(i_in.row_state);
    assign wr_row.pattern = DATA_WIDTH'(i_in.row_pattern);
    assign wr_row.mask    = DATA_WIDTH'(i_in.row_mask);
    assign wr_row.next    = STATE_WIDTH'(i_in.row_next);
    assign wr_row.outval  = DATA_WIDTH'(i_in.row_output);
    assign ram_we         = load && (32'(i_in.row_index) < ROWS);

    assign req.start   = accept && (i_in.operation == OP_CLOCK);
    assign req.unknown = i_in.in_unknown;
    assign req.x       = DATA_WIDTH'(i_in.in_value) & width_mask(r_input_bits);
    assign req.omask   = width_mask(r_output_bits);
    assign req.count   = (32'(r_row_count) > ROWS) ? CNT_W'(ROWS) : CNT_W'(r_row_count);

    tdfs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ROW_AW'(i_in.row_index)),
        .i_wdata (wr_row),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_row)
    );

    tdfs_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_res_ready (slot_free),
        .i_rd_data   (rd_row),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_res       (res),
        .o_status    (status)
    );

    // A load item reports the current output and state with no change.
    always_comb begin
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_value   = r_out_value;
        n_out_unknown = r_out_unknown;
        n_out_changed = r_out_changed;
        n_out_state   = r_out_state;
        if (res.done) begin
            n_out_valid   = 1'b1;
            n_out_value   = 16'(res.value);
            n_out_unknown = res.unknown;
            n_out_changed = res.changed;
            n_out_state   = 8'(res.state);
        end else if (load) begin
            n_out_valid   = 1'b1;
            n_out_value   = 16'(status.last_out);
            n_out_unknown = status.last_unk;
            n_out_changed = 1'b0;
            n_out_state   = 8'(status.state);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value   <= n_out_value;
        r_out_unknown <= n_out_unknown;
        r_out_changed <= n_out_changed;
        r_out_state   <= n_out_state;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_value     = r_out_value;
    assign o_out.out_unknown   = r_out_unknown;
    assign o_out.out_changed   = r_out_changed;
    assign o_out.present_state = r_out_state;

endmodule

`default_nettype wire

/* rtl/tdfs_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. No dependencies.
`default_nettype none

module tdfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/tdfs_engine.sv */
// Scan engine: holds the machine state and last output, and walks the row
// table RAM once for the transition and once for the output of the new state.
// Depends on tdfs_pkg.
`default_nettype none

module tdfs_engine (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tdfs_pkg::t_scan_req           i_req,
    input  wire logic                          i_res_ready,
    input  wire tdfs_pkg::t_row                i_rd_data,
    output logic                               o_rd_en,
    output logic     [tdfs_pkg::ROW_AW-1:0]    o_rd_addr,
    output tdfs_pkg::t_scan_res                o_res,
    output tdfs_pkg::t_status                  o_status
);
    import tdfs_pkg::*;

    t_phase                 r_phase, n_phase;
    logic                   r_pend, n_pend;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]       r_n, n_n;
    logic [DATA_WIDTH-1:0]  r_x, n_x;
    logic [DATA_WIDTH-1:0]  r_omask, n_omask;
    logic [STATE_WIDTH-1:0] r_next, n_next;
    logic [STATE_WIDTH-1:0] r_state, n_state;
    logic [DATA_WIDTH-1:0]  r_res_value, n_res_value;
    logic                   r_res_unk, n_res_unk;
    logic [DATA_WIDTH-1:0]  r_last_out, n_last_out;
    logic                   r_last_unk, n_last_unk;

    logic hit_t, hit_o, more, issue, done;

    // r_pend marks that the RAM output holds the row issued in the previous cycle.
    assign hit_t = r_pend && (i_rd_data.state == r_state)
                   && (i_rd_data.pattern == (r_x & i_rd_data.mask));
    assign hit_o = r_pend && (i_rd_data.state == r_next);
    assign more  = (r_idx < r_n);
    assign done  = (r_phase == PH_FINISH) && i_res_ready;

    always_comb begin
        case (r_phase)
            PH_SCAN_T: issue = more && !hit_t;
            PH_SCAN_O: issue = more && !hit_o;
            default:   issue = 1'b0;
        endcase
    end

    assign o_rd_en   = issue;
    assign o_rd_addr = r_idx[ROW_AW-1:0];

    always_comb begin
        n_phase     = r_phase;
        n_pend      = issue;
        n_idx       = issue ? r_idx + 1'b1 : r_idx;
        n_n         = r_n;
        n_x         = r_x;
        n_omask     = r_omask;
        n_next      = r_next;
        n_state     = r_state;
        n_res_value = r_res_value;
        n_res_unk   = r_res_unk;
        n_last_out  = r_last_out;
        n_last_unk  = r_last_unk;
        case (r_phase)
            PH_IDLE: begin
                if (i_req.start) begin
                    n_x     = i_req.x;
                    n_omask = i_req.omask;
                    n_n     = i_req.count;
                    n_idx   = '0;
                    if (i_req.unknown) begin
                        n_res_value = '0;
                        n_res_unk   = 1'b1;
                        n_phase     = PH_FINISH;
                    end else begin
                        n_phase = PH_SCAN_T;
                    end
                end
            end
            PH_SCAN_T: begin
                if (hit_t) begin
                    n_next  = i_rd_data.next;
                    n_idx   = '0;
                    n_phase = PH_SCAN_O;
                end else if (!issue && !r_pend) begin
                    n_res_value = '0;
                    n_res_unk   = 1'b1;
                    n_phase     = PH_FINISH;
                end
            end
            PH_SCAN_O: begin
                // The transition has happened whether or not an output row exists.
                if (hit_o) begin
                    n_res_value = i_rd_data.outval & r_omask;
                    n_res_unk   = 1'b0;
                    n_state     = r_next;
                    n_phase     = PH_FINISH;
                end else if (!issue && !r_pend) begin
                    n_res_value = '0;
                    n_res_unk   = 1'b1;
                    n_state     = r_next;
                    n_phase     = PH_FINISH;
                end
            end
            PH_FINISH: begin
                if (done) begin
                    n_last_out = r_res_value;
                    n_last_unk = r_res_unk;
                    n_phase    = PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_pend     <= 1'b0;
            r_state    <= '0;
            r_last_out <= '0;
            r_last_unk <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_pend     <= n_pend;
            r_state    <= n_state;
            r_last_out <= n_last_out;
            r_last_unk <= n_last_unk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_n         <= n_n;
        r_x         <= n_x;
        r_omask     <= n_omask;
        r_next      <= n_next;
        r_res_value <= n_res_value;
        r_res_unk   <= n_res_unk;
    end

    assign o_res.done    = done;
    assign o_res.value   = r_res_value;
    assign o_res.unknown = r_res_unk;
    assign o_res.changed = (r_res_unk != r_last_unk) || (r_res_value != r_last_out);
    assign o_res.state   = r_state;

    assign o_status.idle     = (r_phase == PH_IDLE);
    assign o_status.state    = r_state;
    assign o_status.last_out = r_last_out;
    assign o_status.last_unk = r_last_unk;

    a_pend_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_idx != '0) && (r_idx <= r_n))
        else $error("pending read without a matching issued row");

    a_state_moves_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != $past(r_state)) |-> ($past(r_phase) == PH_SCAN_O))
        else $error("state changed outside the output scan");

    a_unknown_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && r_res_unk) |-> (r_res_value == '0))
        else $error("unknown result with nonzero value");

    a_last_follows_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (r_last_out == $past(r_res_value)) && (r_last_unk == $past(r_res_unk))
                 && (r_phase == PH_IDLE))
        else $error("last output not updated after a result");

endmodule

`default_nettype wire
